FILE: rtl/core/mvsc_pkg.sv
`timescale 1ns / 1ps

package mvsc_pkg;

  // start code values of interest
  localparam logic [7:0] CODE_PICTURE   = 8'h00;
  localparam logic [7:0] CODE_SYS_FIRST = 8'hB0;
  localparam logic [7:0] CODE_RESERVED  = 8'hB2;
  localparam logic [7:0] CODE_EXTENSION = 8'hB5;
  localparam logic [7:0] CODE_SEQ_END   = 8'hB7;
  localparam logic [7:0] CODE_GROUP     = 8'hB8;

  // picture coding type field of the picture header
  localparam logic [7:0] PT_MASK  = 8'h38;
  localparam logic [7:0] PT_FLD_I = 8'h08;
  localparam logic [7:0] PT_FLD_P = 8'h10;
  localparam logic [7:0] PT_FLD_B = 8'h18;

  localparam logic [1:0] PTYPE_UNKNOWN = 2'd0;
  localparam logic [1:0] PTYPE_I       = 2'd1;
  localparam logic [1:0] PTYPE_P       = 2'd2;
  localparam logic [1:0] PTYPE_B       = 2'd3;

  // bytes still to pass after a flagged prefix: rest of prefix, code and header
  localparam logic [2:0] SKIP_PICTURE = 3'd7;
  localparam logic [2:0] SKIP_OTHER   = 3'd3;

  localparam int HDR_BYTES = 6;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
    logic [1:0] ptype;
    logic [9:0] tref;
  } hdr_info_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       capture;
    logic       capture_restart;
    logic       start_code_seen;
    logic [7:0] start_code_value;
    logic [1:0] picture_type;
    logic [9:0] temporal_ref;
    logic       still_picture;
  } result_t;

  typedef struct packed {
    logic main_full;
    logic skid_full;
  } skid_status_t;

endpackage

FILE: rtl/core/mvsc_hdr_decode.sv
`timescale 1ns / 1ps

module mvsc_hdr_decode (
  input  logic [mvsc_pkg::HDR_BYTES-1:0][7:0] win,
  output mvsc_pkg::hdr_info_t                 info
);
  import mvsc_pkg::*;

  logic       prefix;
  logic       code_ok;
  logic [7:0] pt_fld;

  always_comb begin
    prefix  = (win[0] == 8'h00) && (win[1] == 8'h00) && (win[2] == 8'h01);
    code_ok = (win[3] == CODE_PICTURE) ||
              ((win[3] >= CODE_SYS_FIRST) && (win[3] != CODE_RESERVED) &&
               (win[3] != CODE_EXTENSION));
    pt_fld  = win[5] & PT_MASK;

    info.hit  = prefix && code_ok;
    info.code = win[3];
    info.tref = {win[4], win[5][7:6]};
    case (pt_fld)
      PT_FLD_I: info.ptype = PTYPE_I;
      PT_FLD_P: info.ptype = PTYPE_P;
      PT_FLD_B: info.ptype = PTYPE_B;
      default:  info.ptype = PTYPE_UNKNOWN;
    endcase
  end

endmodule

FILE: rtl/core/mvsc_out_skid.sv
`timescale 1ns / 1ps

module mvsc_out_skid (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_stall,
  input  mvsc_pkg::result_t      push_data,
  output logic                   pop_valid,
  input  logic                   pop_stall,
  output mvsc_pkg::result_t      pop_data,
  output mvsc_pkg::skid_status_t status
);
  import mvsc_pkg::*;

  logic    main_full;
  logic    skid_full;
  result_t main_data;
  result_t skid_data;
  logic    push;
  logic    pop;

  assign push_stall = skid_full;
  assign pop_valid  = main_full;
  assign pop_data   = main_data;
  assign push       = push_valid && !skid_full;
  assign pop        = main_full && !pop_stall;
  assign status     = '{main_full: main_full, skid_full: skid_full};

  always_ff @(posedge clk) begin
    if (rst) begin
      main_full <= 1'b0;
      skid_full <= 1'b0;
    end else if (pop) begin
      if (skid_full) begin
        main_data <= skid_data;
        skid_full <= 1'b0;
      end else if (push) begin
        main_data <= push_data;
      end else begin
        main_full <= 1'b0;
      end
    end else if (push) begin
      if (!main_full) begin
        main_data <= push_data;
        main_full <= 1'b1;
      end else begin
        skid_data <= push_data;
        skid_full <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/mpeg_video_start_code_scanner.sv
`timescale 1ns / 1ps
// channel | handshake              | payload
// --------+------------------------+--------------------------------------------
// input   | in_valid / in_stall    | data_byte
// result  | res_valid / res_stall  | out_valid out_byte capture capture_restart
//         |                        | start_code_seen start_code_value
//         |                        | picture_type temporal_ref still_picture
//
// one request in, one result out, one per cycle while res_stall is low;
// the result goes to the output register, or the skid stage behind a held result
// the per-byte decision is one compare-and-select pass over the delay line taps
// rst (synchronous) empties the delay line count and the output stages
// a stalled result sits in the output register while one more request lands in
// the skid stage; in_stall rises only once the skid stage is occupied

module mpeg_video_start_code_scanner #(
  parameter int DELAY_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       capture,
  output logic       capture_restart,
  output logic       start_code_seen,
  output logic [7:0] start_code_value,
  output logic [1:0] picture_type,
  output logic [9:0] temporal_ref,
  output logic       still_picture
);
  import mvsc_pkg::*;

  localparam int FILL_W = $clog2(DELAY_BYTES + 1);

  // delay line: tap 0 is the oldest byte, younger taps are lookahead
  logic [7:0]        delay_line [DELAY_BYTES];
  logic [FILL_W-1:0] fill_count;
  logic [2:0]        skip_count;
  logic              save_active;
  logic [9:0]        last_ref;
  logic              last_ref_valid;
  logic              capture_nonempty;

  logic [FILL_W-1:0] fill_count_next;
  logic [2:0]        skip_count_next;
  logic              save_active_next;
  logic [9:0]        last_ref_next;
  logic              last_ref_valid_next;
  logic              capture_nonempty_next;

  logic                        accept;
  logic                        line_full;
  logic [HDR_BYTES-1:0][7:0]   win;
  hdr_info_t                   hdr;
  result_t                     res;
  result_t                     res_q;
  skid_status_t                skid_st;

  assign accept    = in_valid && !in_stall;
  assign line_full = (fill_count == FILL_W'(DELAY_BYTES));

  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      win[i] = delay_line[i];
    end
  end

  mvsc_hdr_decode u_hdr (
    .win  (win),
    .info (hdr)
  );

  // per-byte decision
  always_comb begin
    fill_count_next       = fill_count;
    skip_count_next       = skip_count;
    save_active_next      = save_active;
    last_ref_next         = last_ref;
    last_ref_valid_next   = last_ref_valid;
    capture_nonempty_next = capture_nonempty;
    res                   = '0;

    if (!line_full) begin
      // still filling: all-zero result
      fill_count_next = fill_count + FILL_W'(1);
    end else begin
      res.out_valid = 1'b1;
      res.out_byte  = delay_line[0];
      if (skip_count != 3'd0) begin
        skip_count_next = skip_count - 3'd1;
      end else if (hdr.hit) begin
        res.start_code_seen  = 1'b1;
        res.start_code_value = hdr.code;
        if (hdr.code == CODE_PICTURE) begin
          res.picture_type = hdr.ptype;
          res.temporal_ref = hdr.tref;
          if (hdr.ptype == PTYPE_I || hdr.ptype == PTYPE_P) begin
            // new reference picture, a repeated one is its second field
            if (!last_ref_valid || hdr.tref != last_ref) begin
              res.capture_restart   = 1'b1;
              save_active_next      = 1'b1;
              capture_nonempty_next = 1'b0;
              last_ref_next         = hdr.tref;
              last_ref_valid_next   = 1'b1;
            end
          end else begin
            save_active_next = 1'b0;
          end
          skip_count_next = SKIP_PICTURE;
        end else begin
          if (hdr.code == CODE_SEQ_END && capture_nonempty) begin
            res.still_picture = 1'b1;
          end
          if (hdr.code == CODE_GROUP) begin
            last_ref_valid_next = 1'b0;
          end
          save_active_next = 1'b0;
          skip_count_next  = SKIP_OTHER;
        end
      end
      res.capture = save_active_next;
      if (save_active_next) begin
        capture_nonempty_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count       <= '0;
      skip_count       <= 3'd0;
      save_active      <= 1'b0;
      last_ref_valid   <= 1'b0;
      capture_nonempty <= 1'b0;
    end else if (accept) begin
      fill_count       <= fill_count_next;
      skip_count       <= skip_count_next;
      save_active      <= save_active_next;
      last_ref_valid   <= last_ref_valid_next;
      capture_nonempty <= capture_nonempty_next;
    end
  end

  // payload: the line shifts on every request, filling included
  always_ff @(posedge clk) begin
    if (accept) begin
      last_ref <= last_ref_next;
      for (int i = 0; i < DELAY_BYTES - 1; i++) begin
        delay_line[i] <= delay_line[i+1];
      end
      delay_line[DELAY_BYTES-1] <= data_byte;
    end
  end

  mvsc_out_skid u_out (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_data  (res),
    .pop_valid  (res_valid),
    .pop_stall  (res_stall),
    .pop_data   (res_q),
    .status     (skid_st)
  );

  assign out_valid        = res_q.out_valid;
  assign out_byte         = res_q.out_byte;
  assign capture          = res_q.capture;
  assign capture_restart  = res_q.capture_restart;
  assign start_code_seen  = res_q.start_code_seen;
  assign start_code_value = res_q.start_code_value;
  assign picture_type     = res_q.picture_type;
  assign temporal_ref     = res_q.temporal_ref;
  assign still_picture    = res_q.still_picture;

  // skid stage only fills behind a held result
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_st.skid_full |-> (skid_st.main_full && res_valid))
    else $error("skid stage holds a result while the output register is empty");

  // a restart only comes from an I or P picture header
  a_restart_on_ref_pic: assert property (@(posedge clk) disable iff (rst)
    (res_valid && capture_restart) |->
      (start_code_seen && start_code_value == CODE_PICTURE &&
       (picture_type == PTYPE_I || picture_type == PTYPE_P) && capture))
    else $error("capture restart without a reference picture start");

  // still picture only on a sequence end code
  a_still_on_seq_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && still_picture) |->
      (start_code_seen && start_code_value == CODE_SEQ_END))
    else $error("still picture flagged outside a sequence end code");

  // header skipping counts down one per byte
  a_skip_countdown: assert property (@(posedge clk) disable iff (rst)
    (accept && skip_count != 3'd0) |=> (skip_count == $past(skip_count) - 3'd1))
    else $error("header skip count did not step down");

endmodule

FILE: test/tb_mpeg_video_start_code_scanner.sv
`timescale 1ns / 1ps

module tb_mpeg_video_start_code_scanner;
  import mvsc_pkg::*;

  localparam int DELAY_BYTES  = 8;
  // longest wait either side draws per request
  localparam int MAX_WAIT     = 17;
  // cycles with no handshake on either channel before the run is declared hung
  localparam int IDLE_LIMIT   = 2000;
  localparam int NOGAP_ITEMS  = 300;
  localparam int TOTAL_ITEMS  = 1900;
  // quiet wait after the last result, allow a little margin
  localparam int DRAIN_CYCLES = 8;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       res_stall = 1'b0;

  logic       in_stall;
  logic       res_valid;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       capture;
  logic       capture_restart;
  logic       start_code_seen;
  logic [7:0] start_code_value;
  logic [1:0] picture_type;
  logic [9:0] temporal_ref;
  logic       still_picture;

  mpeg_video_start_code_scanner #(
    .DELAY_BYTES(DELAY_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .out_valid(out_valid),
    .out_byte(out_byte),
    .capture(capture),
    .capture_restart(capture_restart),
    .start_code_seen(start_code_seen),
    .start_code_value(start_code_value),
    .picture_type(picture_type),
    .temporal_ref(temporal_ref),
    .still_picture(still_picture)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // scanner state mirrored on the testbench side
  logic [7:0] line_q [DELAY_BYTES];
  int         fill_q       = 0;
  int         skip_q       = 0;
  bit         saving       = 1'b0;
  logic [9:0] ref_q        = '0;
  bit         ref_known    = 1'b0;
  bit         cap_has_data = 1'b0;

  // results predicted for accepted requests, oldest first
  result_t    expected_q [$];

  int         err_count    = 0;
  int         items_sent   = 0;
  int         idle_cycles  = 0;
  int         hold_left    = 0;
  // chance in percent that a side waits before a request
  int         in_busy_pct  = 50;
  int         out_busy_pct = 50;
  // last temporal reference sent, reused to hit the second-field case
  logic [9:0] last_tref    = '0;
  result_t    got_r;
  result_t    want_r;

  initial begin
    foreach (line_q[i]) line_q[i] = 8'h00;
  end

  // classify one byte leaving the delay line and shift the new byte in
  function automatic result_t scan_byte(logic [7:0] b);
    result_t    r;
    logic [9:0] tr;
    logic [7:0] pt;
    r = '0;
    // line still filling: everything reads zero
    if (fill_q < DELAY_BYTES) begin
      line_q[fill_q] = b;
      fill_q++;
      return r;
    end
    r.out_valid = 1'b1;
    r.out_byte  = line_q[0];
    if (skip_q > 0) begin
      // rest of a header, no code search
      skip_q--;
    end else if (line_q[0] == 8'h00 && line_q[1] == 8'h00 && line_q[2] == 8'h01 &&
                 (line_q[3] == CODE_PICTURE ||
                  (line_q[3] >= CODE_SYS_FIRST && line_q[3] != CODE_RESERVED &&
                   line_q[3] != CODE_EXTENSION))) begin
      r.start_code_seen  = 1'b1;
      r.start_code_value = line_q[3];
      if (line_q[3] == CODE_PICTURE) begin
        tr = {line_q[4], line_q[5][7:6]};
        pt = line_q[5] & PT_MASK;
        case (pt)
          PT_FLD_I: r.picture_type = PTYPE_I;
          PT_FLD_P: r.picture_type = PTYPE_P;
          PT_FLD_B: r.picture_type = PTYPE_B;
          default:  r.picture_type = PTYPE_UNKNOWN;
        endcase
        r.temporal_ref = tr;
        if (r.picture_type == PTYPE_I || r.picture_type == PTYPE_P) begin
          // a repeated reference is the second field and changes nothing
          if (!ref_known || tr != ref_q) begin
            r.capture_restart = 1'b1;
            saving            = 1'b1;
            cap_has_data      = 1'b0;
            ref_q             = tr;
            ref_known         = 1'b1;
          end
        end else begin
          saving = 1'b0;
        end
        skip_q = SKIP_PICTURE;
      end else begin
        if (line_q[3] == CODE_SEQ_END && cap_has_data) r.still_picture = 1'b1;
        if (line_q[3] == CODE_GROUP) ref_known = 1'b0;
        saving = 1'b0;
        skip_q = SKIP_OTHER;
      end
    end
    r.capture = saving;
    if (saving) cap_has_data = 1'b1;
    for (int i = 0; i < DELAY_BYTES - 1; i++) line_q[i] = line_q[i + 1];
    line_q[DELAY_BYTES - 1] = b;
    return r;
  endfunction

  function automatic int draw_wait(int busy_pct);
    if ($urandom_range(99) < busy_pct) return $urandom_range(MAX_WAIT);
    return 0;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  // one request: optional gap, then hold valid and payload until accepted
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(in_busy_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(scan_byte(b));
    items_sent++;
  endtask

  // one piece of stream: a header, a code, a broken prefix or nothing, then payload
  task automatic send_stream_unit();
    int         kind;
    int         n;
    logic [9:0] tr;
    logic [7:0] ptf;
    logic [2:0] unk;
    logic [7:0] code;
    kind = $urandom_range(99);
    if (kind < 45) begin
      // picture header with random reference and type
      if ($urandom_range(3) == 0) tr = last_tref;
      else tr = 10'($urandom);
      case ($urandom_range(9))
        0, 1, 2, 3: ptf = PT_FLD_I;
        4, 5, 6:    ptf = PT_FLD_P;
        7, 8:       ptf = PT_FLD_B;
        default: begin
          // coding type field values outside I, P and B
          unk = 3'($urandom_range(4));
          if (unk != 3'd0) unk = unk + 3'd3;
          ptf = {2'b00, unk, 3'b000};
        end
      endcase
      last_tref = tr;
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(CODE_PICTURE);
      send_byte(tr[9:2]);
      send_byte({tr[1:0], 6'b0} | ptf | 8'($urandom_range(7)));
    end else if (kind < 72) begin
      // other codes, accepted and rejected alike
      case ($urandom_range(7))
        0:       code = CODE_SEQ_END;
        1:       code = CODE_GROUP;
        2:       code = CODE_RESERVED;
        3:       code = CODE_EXTENSION;
        4:       code = 8'($urandom_range(8'hFF, 8'hB0));
        5:       code = 8'($urandom_range(8'hAF, 8'h01));
        6:       code = CODE_SYS_FIRST;
        default: code = 8'hFF;
      endcase
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(code);
    end else if (kind < 85) begin
      // truncated or stretched prefix
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'h00);
      if ($urandom_range(1)) send_byte(8'h01);
      send_byte(8'($urandom));
    end
    n = $urandom_range(0, 10);
    repeat (n) send_byte(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom));
  endtask

  // fill phase plus I picture, sequence end, extension, group and unknown-type picture headers, extremes of the byte
  task automatic test_header_cases();
    logic [7:0] hdr_seq [26];
    in_busy_pct  = 50;
    out_busy_pct = 50;
    hdr_seq = '{
      // I picture, reference 12
      8'h00, 8'h00, 8'h01, CODE_PICTURE, 8'h03, 8'h0A, 8'hFF, 8'hFF,
      // sequence end while capture holds data
      8'h00, 8'h00, 8'h01, CODE_SEQ_END,
      // extension code is rejected and passes as data
      8'h00, 8'h00, 8'h01, CODE_EXTENSION,
      // group start drops the reference
      8'h00, 8'h00, 8'h01, CODE_GROUP,
      // picture with all-ones reference and unknown type
      8'h00, 8'h00, 8'h01, CODE_PICTURE, 8'hFF, 8'hFF
    };
    foreach (hdr_seq[i]) send_byte(hdr_seq[i]);
  endtask

  // back-to-back requests, receiver draws no further stalls
  task automatic test_streaming_no_gaps();
    int stop_at;
    in_busy_pct  = 0;
    out_busy_pct = 0;
    stop_at = items_sent + NOGAP_ITEMS;
    while (items_sent < stop_at) send_stream_unit();
  endtask

  // mostly well-formed stream, idling mix redrawn once a hundred more requests have gone
  task automatic test_random_stream();
    int next_mix;
    next_mix = items_sent;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= next_mix) begin
        case ($urandom_range(3))
          0:       in_busy_pct = 0;
          1:       in_busy_pct = 100;
          default: in_busy_pct = $urandom_range(100);
        endcase
        case ($urandom_range(3))
          0:       out_busy_pct = 0;
          1:       out_busy_pct = 100;
          default: out_busy_pct = $urandom_range(100);
        endcase
        next_mix = items_sent + 100;
      end
      send_stream_unit();
    end
  endtask

  // result side: random stall per result, compare against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (res_valid && !res_stall) begin
        got_r = {out_valid, out_byte, capture, capture_restart, start_code_seen,
                 start_code_value, picture_type, temporal_ref, still_picture};
        if (expected_q.size() == 0) begin
          $error("result with no request pending: out_byte 0x%0h", out_byte);
          err_count++;
        end else begin
          want_r = expected_q.pop_front();
          check_field("out_valid", want_r.out_valid, got_r.out_valid);
          check_field("out_byte", want_r.out_byte, got_r.out_byte);
          check_field("capture", want_r.capture, got_r.capture);
          check_field("capture_restart", want_r.capture_restart, got_r.capture_restart);
          check_field("start_code_seen", want_r.start_code_seen, got_r.start_code_seen);
          check_field("start_code_value", want_r.start_code_value, got_r.start_code_value);
          check_field("picture_type", want_r.picture_type, got_r.picture_type);
          check_field("temporal_ref", want_r.temporal_ref, got_r.temporal_ref);
          check_field("still_picture", want_r.still_picture, got_r.still_picture);
        end
        hold_left = draw_wait(out_busy_pct);
      end
      // stall budget also runs down while nothing is offered
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // hang detection: no handshake on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (res_valid && !res_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    // single reset at the start of the run
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_header_cases();
    test_streaming_no_gaps();
    test_random_stream();
    in_valid <= 1'b0;
    // let every outstanding result come out, then the quiet drain wait
    while (expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
